[sv/csev_pkg.sv]
// Shared constants, types and helper functions of the cubic spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
package csev_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = $clog2(MAX_KNOTS);
    localparam int CNT_W     = 7;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int DIVCNT_W  = $clog2(DIV_W);
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int Q_W       = 2 * DATA_W - FRAC_BITS;
    localparam int ACC_W     = ((Q_W > DIV_W) ? Q_W : DIV_W) + 2;
    localparam int DIV6_SH   = 34;
    localparam int CORR_W    = 2 * DATA_W - DIV6_SH;
    localparam logic [MUL_W-1:0] RECIP6 = {1'b0, 32'hAAAA_AAAB};

    localparam int MUL_STEPS = 22;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_REP = 2'd2;
    localparam logic [1:0] ST_SAT = 2'd3;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_INIT, OP_ERR_FEW, OP_BIS_RD, OP_BIS_CMP, OP_RD_LO,
        OP_RD_HI, OP_CAP_HI, OP_H, OP_ERR_REP, OP_DIVA_INIT, OP_DIVB_INIT,
        OP_DIV_STEP, OP_DIVA_END, OP_DIVB_END, OP_M_AA, OP_W_SQ, OP_M_SQA,
        OP_W_CA, OP_M_BB, OP_M_SQB, OP_W_CB, OP_M_CA, OP_W_P1, OP_M_CB, OP_W_T,
        OP_M_HH, OP_W_HH, OP_M_THH, OP_W_THH, OP_M_DIV6, OP_W_DIV6, OP_M_AY,
        OP_W_AY, OP_M_BY, OP_W_BY, OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic too_few;
        logic bis_done;
        logic h_zero;
        logic div_last;
    } t_stat;

    // Fixed order of the multiply and write-back steps after both weights are known.
    function automatic t_op mul_seq_op(input logic [STEP_W-1:0] step);
        t_op op;
        unique case (step)
            5'd0:    op = OP_M_AA;
            5'd1:    op = OP_W_SQ;
            5'd2:    op = OP_M_SQA;
            5'd3:    op = OP_W_CA;
            5'd4:    op = OP_M_BB;
            5'd5:    op = OP_W_SQ;
            5'd6:    op = OP_M_SQB;
            5'd7:    op = OP_W_CB;
            5'd8:    op = OP_M_CA;
            5'd9:    op = OP_W_P1;
            5'd10:   op = OP_M_CB;
            5'd11:   op = OP_W_T;
            5'd12:   op = OP_M_HH;
            5'd13:   op = OP_W_HH;
            5'd14:   op = OP_M_THH;
            5'd15:   op = OP_W_THH;
            5'd16:   op = OP_M_DIV6;
            5'd17:   op = OP_W_DIV6;
            5'd18:   op = OP_M_AY;
            5'd19:   op = OP_W_AY;
            5'd20:   op = OP_M_BY;
            5'd21:   op = OP_W_BY;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    // True when a wide value does not fit the signed data range.
    function automatic logic ovf(input logic [ACC_W-1:0] v);
        return !((&v[ACC_W-1:DATA_W-1]) || (~|v[ACC_W-1:DATA_W-1]));
    endfunction

    // Clamp a wide value to the signed data range.
    function automatic logic [DATA_W-1:0] sat(input logic [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (ovf(v)) begin
            r = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] ext_d(input logic [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage
`default_nettype wire

[sv/csev_datapath.sv]
// Datapath of the spline evaluator: knot memories, bisection, divider, multiplier.
`timescale 1ns / 1ps
`default_nettype none
module csev_datapath
    import csev_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]         i_cfg_wr_data,
    input  wire logic [IDX_W-1:0]         i_knot_index,
    input  wire logic [DATA_W-1:0]        i_knot_x,
    input  wire logic [DATA_W-1:0]        i_knot_y,
    input  wire logic [DATA_W-1:0]        i_knot_curv,
    input  wire logic [DATA_W-1:0]        i_query_x,
    output logic      [DATA_W-1:0]        o_value,
    output logic      [1:0]               o_status
);

    logic [DATA_W-1:0] mem_x [0:MAX_KNOTS-1];
    logic [DATA_W-1:0] mem_y [0:MAX_KNOTS-1];
    logic [DATA_W-1:0] mem_c [0:MAX_KNOTS-1];

    logic [CNT_W-1:0]    r_knot_count;
    logic [DATA_W-1:0]   r_x, r_rdx, r_rdy, r_rdc;
    logic [DATA_W-1:0]   r_xlo, r_xhi, r_ylo, r_yhi, r_clo, r_chi;
    logic [IDX_W-1:0]    r_lo, r_hi;
    logic [DATA_W:0]     r_h;
    logic [DATA_W-1:0]   r_rem, r_den;
    logic [DIV_W-1:0]    r_quo;
    logic [DIVCNT_W-1:0] r_cnt;
    logic                r_neg;
    logic [DATA_W-1:0]   r_a, r_b, r_w, r_ca, r_cb, r_t, r_hh;
    logic [ACC_W-1:0]    r_acc;
    logic [PROD_W-1:0]   r_prod;
    logic                r_sat;
    logic [DATA_W-1:0]   r_rv, r_out_val;
    logic [1:0]          r_rs, r_out_st;

    t_op               op;
    logic [CNT_W-1:0]  n_used;
    logic [IDX_W-1:0]  mid, span, rd_addr;
    logic [DATA_W:0]   num, num_abs, h_abs;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] trial;
    logic [ACC_W-1:0]  q_ext, div_ext, div_val, hs_wide, cu_diff, sum_q, corr_ext;
    logic [DATA_W-1:0] hs, w_abs;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              mul_go;

    assign op      = i_cmd.op;
    assign n_used  = (r_knot_count > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : r_knot_count;
    assign span    = r_hi - r_lo;
    assign mid     = r_lo + (span >> 1);

    assign o_stat.too_few  = n_used < CNT_W'(2);
    assign o_stat.bis_done = span <= IDX_W'(1);
    assign o_stat.h_zero   = r_xhi == r_xlo;
    assign o_stat.div_last = r_cnt == DIVCNT_W'(DIV_W - 1);

    always_comb begin
        unique case (op)
            OP_BIS_RD: rd_addr = mid;
            OP_RD_LO:  rd_addr = r_lo;
            default:   rd_addr = r_hi;
        endcase
    end

    // Divider operands: numerator is xhi-x for the A weight and x-xlo for B.
    always_comb begin
        if (op == OP_DIVA_INIT) begin
            num = {r_xhi[DATA_W-1], r_xhi} - {r_x[DATA_W-1], r_x};
        end else begin
            num = {r_x[DATA_W-1], r_x} - {r_xlo[DATA_W-1], r_xlo};
        end
        num_abs = num[DATA_W] ? -num : num;
        h_abs   = r_h[DATA_W] ? -r_h : r_h;
        shifted = {r_rem, r_quo[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        div_ext = {{(ACC_W-DIV_W){1'b0}}, r_quo};
        div_val = r_neg ? -div_ext : div_ext;
    end

    always_comb begin
        q_ext    = {{(ACC_W-Q_W){r_prod[2*DATA_W-1]}}, r_prod[2*DATA_W-1:FRAC_BITS]};
        hs_wide  = {{(ACC_W-DATA_W-1){r_h[DATA_W]}}, r_h};
        hs       = sat(hs_wide);
        w_abs    = r_w[DATA_W-1] ? -r_w : r_w;
        corr_ext = {{(ACC_W-CORR_W){1'b0}}, r_prod[2*DATA_W-1:DIV6_SH]};
        sum_q    = r_acc + q_ext;
        cu_diff  = (op == OP_W_CA) ? ext_d(sat(q_ext)) - ext_d(r_a)
                                   : ext_d(sat(q_ext)) - ext_d(r_b);
    end

    always_comb begin
        mul_go = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (op)
            OP_M_AA:   begin mul_a = {r_a[DATA_W-1], r_a};   mul_b = {r_a[DATA_W-1], r_a}; end
            OP_M_SQA:  begin mul_a = {r_w[DATA_W-1], r_w};   mul_b = {r_a[DATA_W-1], r_a}; end
            OP_M_BB:   begin mul_a = {r_b[DATA_W-1], r_b};   mul_b = {r_b[DATA_W-1], r_b}; end
            OP_M_SQB:  begin mul_a = {r_w[DATA_W-1], r_w};   mul_b = {r_b[DATA_W-1], r_b}; end
            OP_M_CA:   begin mul_a = {r_ca[DATA_W-1], r_ca}; mul_b = {r_clo[DATA_W-1], r_clo}; end
            OP_M_CB:   begin mul_a = {r_cb[DATA_W-1], r_cb}; mul_b = {r_chi[DATA_W-1], r_chi}; end
            OP_M_HH:   begin mul_a = {hs[DATA_W-1], hs};     mul_b = {hs[DATA_W-1], hs}; end
            OP_M_THH:  begin mul_a = {r_t[DATA_W-1], r_t};   mul_b = {r_hh[DATA_W-1], r_hh}; end
            OP_M_DIV6: begin mul_a = {1'b0, w_abs};          mul_b = RECIP6; end
            OP_M_AY:   begin mul_a = {r_a[DATA_W-1], r_a};   mul_b = {r_ylo[DATA_W-1], r_ylo}; end
            OP_M_BY:   begin mul_a = {r_b[DATA_W-1], r_b};   mul_b = {r_yhi[DATA_W-1], r_yhi}; end
            default:   mul_go = 1'b0;
        endcase
    end

    // Knot memories: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (op == OP_LOAD) begin
            mem_x[i_knot_index] <= i_knot_x;
            mem_y[i_knot_index] <= i_knot_y;
            mem_c[i_knot_index] <= i_knot_curv;
        end
        r_rdx <= mem_x[rd_addr];
        r_rdy <= mem_y[rd_addr];
        r_rdc <= mem_c[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_knot_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_go) begin
            r_prod <= PROD_W'($signed(mul_a) * $signed(mul_b));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_INIT: begin
                r_x   <= i_query_x;
                r_lo  <= '0;
                r_hi  <= IDX_W'(n_used - CNT_W'(1));
                r_sat <= 1'b0;
            end
            OP_ERR_FEW: begin
                r_rv <= '0;
                r_rs <= ST_FEW;
            end
            OP_ERR_REP: begin
                r_rv <= '0;
                r_rs <= ST_REP;
            end
            OP_BIS_CMP: begin
                if ($signed(r_rdx) > $signed(r_x)) begin
                    r_hi <= mid;
                end else begin
                    r_lo <= mid;
                end
            end
            OP_RD_HI: begin
                r_xlo <= r_rdx;
                r_ylo <= r_rdy;
                r_clo <= r_rdc;
            end
            OP_CAP_HI: begin
                r_xhi <= r_rdx;
                r_yhi <= r_rdy;
                r_chi <= r_rdc;
            end
            OP_H: r_h <= {r_xhi[DATA_W-1], r_xhi} - {r_xlo[DATA_W-1], r_xlo};
            OP_DIVA_INIT, OP_DIVB_INIT: begin
                r_quo <= {num_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
                r_den <= h_abs[DATA_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= num[DATA_W] ^ r_h[DATA_W];
            end
            OP_DIV_STEP: begin
                if (!trial[DATA_W+1]) begin
                    r_rem <= trial[DATA_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[DATA_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + DIVCNT_W'(1);
            end
            OP_DIVA_END: begin
                r_a   <= sat(div_val);
                r_sat <= r_sat | ovf(div_val);
            end
            OP_DIVB_END: begin
                r_b   <= sat(div_val);
                r_sat <= r_sat | ovf(div_val);
            end
            OP_W_SQ: begin
                r_w   <= sat(q_ext);
                r_sat <= r_sat | ovf(q_ext);
            end
            OP_W_CA: begin
                r_ca  <= sat(cu_diff);
                r_sat <= r_sat | ovf(q_ext) | ovf(cu_diff);
            end
            OP_W_CB: begin
                r_cb  <= sat(cu_diff);
                r_sat <= r_sat | ovf(q_ext) | ovf(cu_diff);
            end
            OP_W_P1: r_acc <= q_ext;
            OP_W_T: begin
                r_t   <= sat(sum_q);
                r_sat <= r_sat | ovf(sum_q);
            end
            OP_M_HH: r_sat <= r_sat | ovf(hs_wide);
            OP_W_HH: begin
                r_hh  <= sat(q_ext);
                r_sat <= r_sat | ovf(q_ext);
            end
            OP_W_THH: begin
                r_w   <= sat(q_ext);
                r_sat <= r_sat | ovf(q_ext);
            end
            OP_W_DIV6: r_acc <= r_w[DATA_W-1] ? -corr_ext : corr_ext;
            OP_W_AY:   r_acc <= sum_q;
            OP_W_BY: begin
                r_rv <= sat(sum_q);
                r_rs <= (r_sat | ovf(sum_q)) ? ST_SAT : ST_OK;
            end
            OP_OUT: begin
                r_out_val <= r_rv;
                r_out_st  <= r_rs;
            end
            default: ;
        endcase
    end

    assign o_value  = r_out_val;
    assign o_status = r_out_st;

`ifndef SYNTH
    a_bis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_BIS_CMP) |-> (r_lo < r_hi))
        else $error("bisection bounds crossed");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_DIVA_END || op == OP_DIVB_END)
            |-> ($past(op) == OP_DIV_STEP && $past(r_cnt) == DIVCNT_W'(DIV_W - 1)))
        else $error("division ended early");
    a_h_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_H) |-> (r_xhi != r_xlo))
        else $error("interval width taken for a repeated knot");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_DIV_STEP) |-> (r_den != '0))
        else $error("division by zero width");
`endif

endmodule
`default_nettype wire

[sv/csev_ctrl.sv]
// Sequencing state machine of the spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
module csev_ctrl
    import csev_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_mode,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd,
    input  wire t_stat i_stat
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_BIS_RD    = 15'b000000000000010,
        S_BIS_CMP   = 15'b000000000000100,
        S_RD_HI     = 15'b000000000001000,
        S_CAP_HI    = 15'b000000000010000,
        S_H_CHK     = 15'b000000000100000,
        S_DIVA_INIT = 15'b000000001000000,
        S_DIVA      = 15'b000000010000000,
        S_DIVA_END  = 15'b000000100000000,
        S_DIVB_INIT = 15'b000001000000000,
        S_DIVB      = 15'b000010000000000,
        S_DIVB_END  = 15'b000100000000000,
        S_MUL       = 15'b001000000000000,
        S_RESULT    = 15'b010000000000000,
        S_SPARE     = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid;

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd.op       = OP_NOP;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        o_cmd.op = OP_LOAD;
                    end else if (i_stat.too_few) begin
                        o_cmd.op = OP_ERR_FEW;
                        n_state  = S_RESULT;
                    end else begin
                        o_cmd.op = OP_INIT;
                        n_state  = S_BIS_RD;
                    end
                end
            end
            S_BIS_RD: begin
                if (i_stat.bis_done) begin
                    o_cmd.op = OP_RD_LO;
                    n_state  = S_RD_HI;
                end else begin
                    o_cmd.op = OP_BIS_RD;
                    n_state  = S_BIS_CMP;
                end
            end
            S_BIS_CMP: begin
                o_cmd.op = OP_BIS_CMP;
                n_state  = S_BIS_RD;
            end
            S_RD_HI: begin
                o_cmd.op = OP_RD_HI;
                n_state  = S_CAP_HI;
            end
            S_CAP_HI: begin
                o_cmd.op = OP_CAP_HI;
                n_state  = S_H_CHK;
            end
            S_H_CHK: begin
                if (i_stat.h_zero) begin
                    o_cmd.op = OP_ERR_REP;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.op = OP_H;
                    n_state  = S_DIVA_INIT;
                end
            end
            S_DIVA_INIT: begin
                o_cmd.op = OP_DIVA_INIT;
                n_state  = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIVA_END;
                end
            end
            S_DIVA_END: begin
                o_cmd.op = OP_DIVA_END;
                n_state  = S_DIVB_INIT;
            end
            S_DIVB_INIT: begin
                o_cmd.op = OP_DIVB_INIT;
                n_state  = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIVB_END;
                end
            end
            S_DIVB_END: begin
                o_cmd.op = OP_DIVB_END;
                n_step   = '0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = mul_seq_op(r_step);
                n_step   = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.op       = OP_OUT;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("loaded result not shown");
    a_mul_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step < STEP_W'(MUL_STEPS)))
        else $error("multiply sequence overran");
`endif

endmodule
`default_nettype wire

[sv/cubic_spline_evaluator_unit.sv]
// Top level of the cubic spline evaluator: controller and datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  input   | in        | i_valid / o_ready  | i_mode, i_knot_index, i_knot_x, i_knot_y,
//          |           |                    | i_knot_curv, i_query_x
//  result  | out       | o_valid / i_ready  | o_value, o_status
//  config  | in        | i_cfg_wr_en        | i_cfg_wr_data (knot_count)
//
// A load beat writes the knot memories while the block stays idle, so load beats can follow
// each other back to back. A query runs a bisection, where each probe is one read of the knot
// memory and one compare, then two serial divisions (one quotient bit per cycle), then a
// sequence of steps on the shared 33x33 multiplier; queries with too few knots or a repeated
// knot end right after the check. The two divisions take most of a query's time.
// Reset is synchronous and active low; it clears the knot count, the controller and the
// result valid flag, while the knot memories hold whatever was there until loaded.
// A finished result waits in the output register while the next beat is accepted; a
// further query stalls only at its very end if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module cubic_spline_evaluator_unit
    import csev_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_mode,
    input  wire logic [IDX_W-1:0]  i_knot_index,
    input  wire logic [DATA_W-1:0] i_knot_x,
    input  wire logic [DATA_W-1:0] i_knot_y,
    input  wire logic [DATA_W-1:0] i_knot_curv,
    input  wire logic [DATA_W-1:0] i_query_x,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_value,
    output logic      [1:0]        o_status,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]  i_cfg_wr_data
);

    // Commands flow from the controller; the datapath reports the few
    // conditions that steer the sequence (count check, bisection end,
    // repeated knot, last divider step).
    t_cmd  cmd;
    t_stat stat;

    csev_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    csev_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_knot_index  (i_knot_index),
        .i_knot_x      (i_knot_x),
        .i_knot_y      (i_knot_y),
        .i_knot_curv   (i_knot_curv),
        .i_query_x     (i_query_x),
        .o_value       (o_value),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

[tb/cubic_spline_evaluator_unit_test.sv]
// Self-checking testbench of the cubic spline evaluator: load and query beats against a predictor.
`timescale 1ns / 1ps
`default_nettype none

// Holds the knot table copy, predicts query results and checks them in order.
class spline_scoreboard;
    logic signed [31:0] abscissa [64];
    logic signed [31:0] ordinate [64];
    logic signed [31:0] curvature[64];
    logic [6:0]         knot_count;
    logic [33:0]        pending_spline[$];   // {status, value}
    int                 mismatches;

    function new();
        knot_count = 0;
        mismatches = 0;
    endfunction

    // Clamp to the signed 32-bit range and note the clamp.
    function longint clamp32(longint v, ref bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            hit = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact product, floor shift by the fraction width.
    function longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function longint cube_minus(longint w, ref bit hit);
        longint sq;
        longint cu;
        sq = clamp32(qmul(w, w), hit);
        cu = clamp32(qmul(sq, w), hit);
        return clamp32(cu - w, hit);
    endfunction

    function void note_beat(bit mode, logic [5:0] idx, logic [31:0] kx, logic [31:0] ky,
                            logic [31:0] kc, logic [31:0] qx);
        int n;
        int lo;
        int hi;
        int mid;
        longint x;
        longint h;
        longint a;
        longint b;
        longint ca;
        longint cb;
        longint t;
        longint hs;
        longint hh;
        longint corr;
        longint v;
        bit hit;
        if (!mode) begin
            abscissa[idx]  = kx;
            ordinate[idx]  = ky;
            curvature[idx] = kc;
            return;
        end
        hit = 0;
        n = (knot_count > 64) ? 64 : knot_count;
        if (n < 2) begin
            pending_spline.push_back({2'd1, 32'd0});
            return;
        end
        x  = longint'($signed(qx));
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (longint'(abscissa[mid]) > x) hi = mid;
            else lo = mid;
        end
        h = longint'(abscissa[hi]) - longint'(abscissa[lo]);
        if (h == 0) begin
            pending_spline.push_back({2'd2, 32'd0});
            return;
        end
        a  = clamp32(((longint'(abscissa[hi]) - x) * 65536) / h, hit);
        b  = clamp32(((x - longint'(abscissa[lo])) * 65536) / h, hit);
        ca = cube_minus(a, hit);
        cb = cube_minus(b, hit);
        t  = clamp32(qmul(ca, curvature[lo]) + qmul(cb, curvature[hi]), hit);
        hs = clamp32(h, hit);
        hh = clamp32(qmul(hs, hs), hit);
        corr = clamp32(qmul(t, hh), hit) / 6;
        v = clamp32(qmul(a, ordinate[lo]) + qmul(b, ordinate[hi]) + corr, hit);
        pending_spline.push_back({hit ? 2'd3 : 2'd0, v[31:0]});
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] status);
        logic [33:0] want;
        if (pending_spline.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: value %h status %0d", value, status);
            return;
        end
        want = pending_spline.pop_front();
        if (want[31:0] !== value || want[33:32] !== status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value %h status %0d, got value %h status %0d",
                         want[31:0], want[33:32], value, status);
        end
    endfunction
endclass

module cubic_spline_evaluator_unit_test;
    import csev_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_ready;
    logic              i_mode = 0;
    logic [IDX_W-1:0]  i_knot_index = '0;
    logic [DATA_W-1:0] i_knot_x = '0;
    logic [DATA_W-1:0] i_knot_y = '0;
    logic [DATA_W-1:0] i_knot_curv = '0;
    logic [DATA_W-1:0] i_query_x = '0;
    logic              o_valid;
    logic              i_ready = 0;
    logic [DATA_W-1:0] o_value;
    logic [1:0]        o_status;
    logic              i_cfg_wr_en = 0;
    logic [CNT_W-1:0]  i_cfg_wr_data = '0;

    spline_scoreboard spline_book;

    // Idle percentages of the two sides, changed by phase.
    int  send_idle_pct = 16;
    int  recv_idle_pct = 56;
    // While set, the receiver holds off entirely so the block backs up.
    bit  recv_hold = 0;
    longint cycle_count = 0;
    // Currently loaded knot count, so random queries only touch written slots.
    int  loaded_knots = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    cubic_spline_evaluator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_knot_index(i_knot_index),
        .i_knot_x(i_knot_x), .i_knot_y(i_knot_y), .i_knot_curv(i_knot_curv),
        .i_query_x(i_query_x),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_status(o_status),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Watchdog: stops a run that hangs and reports it as failed.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver toggles ready on the falling edge and checks beats on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            spline_book.check_result(o_value, o_status);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold)
            i_ready <= 0;
        else
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one beat and wait until it is accepted; the scoreboard notes it at acceptance.
    // Valid drops after each beat and stays low while the sender idles.
    task automatic send_beat(bit mode, logic [5:0] idx, logic [31:0] kx, logic [31:0] ky,
                             logic [31:0] kc, logic [31:0] qx);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid      <= 1;
        i_mode       <= mode;
        i_knot_index <= idx;
        i_knot_x     <= kx;
        i_knot_y     <= ky;
        i_knot_curv  <= kc;
        i_query_x    <= qx;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        spline_book.note_beat(mode, idx, kx, ky, kc, qx);
        @(negedge i_clk);
        i_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic load_knot(int idx, logic [31:0] kx, logic [31:0] ky, logic [31:0] kc);
        send_beat(0, idx[5:0], kx, ky, kc, $urandom);
    endtask

    task automatic query(logic [31:0] qx);
        send_beat(1, 6'($urandom), $urandom, $urandom, $urandom, qx);
    endtask

    // Wait until all results are back, let the block go quiet, then write knot_count.
    task automatic set_knot_count(logic [6:0] count);
        while (spline_book.pending_spline.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= count;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        spline_book.knot_count = count;
    endtask

    // Fill slots 0..n-1 with ascending abscissas of random spacing and random content.
    task automatic load_table(int n, int spacing_bits);
        logic signed [31:0] xk;
        xk = -$signed({1'b0, 31'($urandom_range(0, 1 << 20))}) * (n / 2 + 1);
        for (int k = 0; k < n; k++) begin
            load_knot(k, xk, $urandom, random_curv());
            xk = xk + 1 + $urandom_range(0, (1 << spacing_bits) - 1);
        end
        loaded_knots = n;
    endtask

    function automatic logic [31:0] random_curv();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    // Queries mostly near the table, sometimes anywhere.
    function automatic logic [31:0] random_query();
        int lo;
        int hi;
        if ($urandom_range(9) == 0) return $urandom;
        lo = $urandom_range(0, loaded_knots - 1);
        return $signed(spline_book.abscissa[lo]) + $signed($urandom_range(0, 1 << 18))
               - (1 << 17);
    endfunction

    initial begin
        spline_book = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed part. With no knots in use every query reports too few knots.
        query(32'h0000_0000);
        set_knot_count(7'd1);
        load_knot(0, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
        query(32'h7FFF_FFFF);
        // Two knots: inside, at the ends, and extrapolated to both extremes.
        load_knot(1, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_8000);
        set_knot_count(7'd2);
        query(32'h0002_0000);
        query(32'h0001_0000);
        query(32'h0003_0000);
        query(32'h8000_0000);
        query(32'h7FFF_FFFF);
        // Repeated knot abscissa.
        load_knot(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h0001_0000);
        // Widest interval with extreme ordinates and curvatures saturates.
        load_knot(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        load_knot(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h0000_0000);
        query(32'hFFFF_FFFF);
        // Unsorted table gives a negative interval width.
        load_knot(0, 32'h0005_0000, 32'h0001_0000, 32'h0000_4000);
        load_knot(1, 32'hFFFB_0000, 32'hFFFF_0000, 32'hFFFF_C000);
        query(32'h0000_0000);
        // Full table, then a count above the table size is clamped.
        load_table(64, 16);
        set_knot_count(7'd64);
        query(random_query());
        set_knot_count(7'd127);
        query(random_query());
        query(spline_book.abscissa[63]);

        // Random part in three idle phases with sorted tables of random size.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 16 : 0;
            for (int blk = 0; blk < 10; blk++) begin
                int n;
                n = (blk == 0) ? 64 : $urandom_range(2, 12);
                set_knot_count(7'd0);
                load_table(n, (blk % 3 == 0) ? 24 : 18);
                if ($urandom_range(7) == 0) load_knot(n, $urandom, $urandom, $urandom);
                set_knot_count(7'(n));
                if (phase == 2 && blk == 0) begin
                    fork
                        begin
                            recv_hold = 1;
                            repeat (2000) @(negedge i_clk);
                            recv_hold = 0;
                        end
                    join_none
                end
                repeat (50) begin
                    if ($urandom_range(15) == 0) begin
                        int k;
                        logic [31:0] kx;
                        // Rewrite one knot's content, keeping its abscissa in order.
                        k = $urandom_range(0, n - 1);
                        kx = spline_book.abscissa[k];
                        load_knot(k, kx, $urandom, random_curv());
                    end else begin
                        query(random_query());
                    end
                end
            end
        end

        while (spline_book.pending_spline.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (spline_book.mismatches == 0 && spline_book.pending_spline.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[cubic_spline_evaluator_unit.f]
sv/csev_pkg.sv
sv/csev_datapath.sv
sv/csev_ctrl.sv
sv/cubic_spline_evaluator_unit.sv
tb/cubic_spline_evaluator_unit_test.sv
